[rtl/cdd_pkg.sv]
`timescale 1ns / 1ps

package cdd_pkg;

   localparam int DAY_W = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W = 14;
   localparam int HOUR_W = 5;
   localparam int MINUTE_W = 6;
   localparam int STATUS_W = 2;

   localparam int STAMP_W = DAY_W + MONTH_W + YEAR_W + HOUR_W + MINUTE_W;
   localparam int REQ_FIELDS_W = 2 * STAMP_W;
   localparam int REQ_DATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + 1 + YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_START_BAD = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_END_BAD = 2'd2;

   localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR = 6'd60;
   localparam logic [MINUTE_W-1:0] LAST_MINUTE = 6'd59;
   localparam logic [HOUR_W-1:0] HOURS_PER_DAY = 5'd24;
   localparam logic [HOUR_W-1:0] LAST_HOUR = 5'd23;
   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0] DAYS_LONG = 5'd31;
   localparam logic [DAY_W-1:0] DAYS_SHORT = 5'd30;
   localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;
   localparam logic [DAY_W-1:0] DAYS_FEB = 5'd28;

   // inverse of 25 modulo 2^14 and the largest multiple test value
   localparam logic [YEAR_W-1:0] INV_25 = 14'd7209;
   localparam logic [YEAR_W-1:0] DIV_25_LIMIT = 14'd655;

   typedef struct packed {
      logic [MINUTE_W-1:0] minute;
      logic [HOUR_W-1:0]   hour;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
   } stamp_type;

   typedef struct packed {
      logic ok;
      logic leap;
   } check_type;

   typedef struct packed {
      logic [MINUTE_W-1:0] minutes;
      logic [HOUR_W-1:0]   hours;
      logic [DAY_W-1:0]    days;
      logic [MONTH_W-1:0]  months;
      logic [YEAR_W-1:0]   years;
      logic                swapped;
      logic [STATUS_W-1:0] status;
   } result_type;

   function automatic logic div_by_25(input logic [YEAR_W-1:0] y);
      logic [2*YEAR_W-1:0] prod;
      prod = {{YEAR_W{1'b0}}, y} * {{YEAR_W{1'b0}}, INV_25};
      return prod[YEAR_W-1:0] <= DIV_25_LIMIT;
   endfunction

   // divisible by 400, or by 4 and not by 100
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic d25;
      d25 = div_by_25(y);
      return ((y[3:0] == 4'd0) && d25) || ((y[1:0] == 2'd0) && !d25);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         MONTH_FEB: len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
         default: len = DAYS_LONG;
      endcase
      return len;
   endfunction

endpackage

[rtl/calendar_datetime_difference_unit.sv]
`timescale 1ns / 1ps

// Date-time difference: each item carries two date-times (day, month, year,
// hour, minute). Both are range checked with Gregorian leap years; a bad first
// date gives status 1, a bad second date status 2, both with all fields zero.
// Otherwise the earlier date is subtracted from the later one field by field
// with borrows (swapped set when the first was later). One item is taken every
// clock unless both registers are full and rsp_tready is low. The input register
// loads on the edge that accepts an item, and the result register loads from
// it when empty or when rsp_tready takes the waiting result. The two registers
// let new items enter while an earlier result waits on rsp_tready.
module calendar_datetime_difference_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // start_day, start_month, start_year, start_hour, start_minute,
   // end_day, end_month, end_year, end_hour, end_minute, zero pad
   input  logic [cdd_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status, swapped, diff_years, diff_months, diff_days, diff_hours,
   // diff_minutes, zero pad
   output logic [cdd_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic req_valid_ff;
   logic req_valid_in;
   cdd_pkg::stamp_type start_ff;
   cdd_pkg::stamp_type start_in;
   cdd_pkg::stamp_type end_ff;
   cdd_pkg::stamp_type end_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   cdd_pkg::result_type result_ff;
   cdd_pkg::result_type result_in;
   cdd_pkg::check_type start_check;
   cdd_pkg::check_type end_check;
   logic rsp_load;
   logic req_load;

   assign rsp_load = !rsp_valid_ff || rsp_tready;
   assign req_load = !req_valid_ff || rsp_load;
   assign req_tready = req_load;

   always_comb begin
      req_valid_in = req_load ? req_tvalid : req_valid_ff;
      rsp_valid_in = rsp_load ? req_valid_ff : rsp_valid_ff;
      start_in = cdd_pkg::stamp_type'(req_tdata[cdd_pkg::STAMP_W-1:0]);
      end_in = cdd_pkg::stamp_type'(req_tdata[cdd_pkg::REQ_FIELDS_W-1:cdd_pkg::STAMP_W]);
   end

   cdd_date_check u_start_check (
      .stamp (start_ff),
      .check (start_check)
   );

   cdd_date_check u_end_check (
      .stamp (end_ff),
      .check (end_check)
   );

   cdd_diff u_diff (
      .start_stamp (start_ff),
      .end_stamp   (end_ff),
      .start_check (start_check),
      .end_check   (end_check),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load && req_tvalid) begin
         start_ff <= start_in;
         end_ff <= end_in;
      end
      if (rsp_load && req_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(cdd_pkg::RSP_DATA_W - cdd_pkg::RSP_FIELDS_W){1'b0}}, result_ff};

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> req_valid_ff)
      else $error("accepted item missing from input register");

   a_stage_moves_on: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && rsp_load |=> rsp_valid_ff)
      else $error("item lost between input and result register");

   a_bad_date_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (result_ff.status != cdd_pkg::STATUS_OK) |->
         !result_ff.swapped && (result_ff.years == '0) && (result_ff.months == '0)
         && (result_ff.days == '0) && (result_ff.hours == '0) && (result_ff.minutes == '0))
      else $error("invalid date with nonzero difference");

   a_ok_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (result_ff.status == cdd_pkg::STATUS_OK) |->
         (result_ff.months < cdd_pkg::MONTHS_PER_YEAR) && (result_ff.days < cdd_pkg::DAYS_LONG)
         && (result_ff.hours <= cdd_pkg::LAST_HOUR)
         && (result_ff.minutes <= cdd_pkg::LAST_MINUTE))
      else $error("difference field out of range");

endmodule

[rtl/cdd_date_check.sv]
`timescale 1ns / 1ps

module cdd_date_check (
   input  cdd_pkg::stamp_type stamp,
   output cdd_pkg::check_type check
);

   logic leap;
   logic [cdd_pkg::DAY_W-1:0] len;

   always_comb begin
      leap = cdd_pkg::is_leap(stamp.year);
      len = cdd_pkg::month_len(stamp.month, leap);
      check.leap = leap;
      check.ok = (stamp.hour <= cdd_pkg::LAST_HOUR)
              && (stamp.minute <= cdd_pkg::LAST_MINUTE)
              && (stamp.month >= cdd_pkg::MONTH_JAN)
              && (stamp.month <= cdd_pkg::MONTH_DEC)
              && (stamp.day != '0)
              && (stamp.day <= len);
   end

endmodule

[rtl/cdd_diff.sv]
`timescale 1ns / 1ps

module cdd_diff (
   input  cdd_pkg::stamp_type  start_stamp,
   input  cdd_pkg::stamp_type  end_stamp,
   input  cdd_pkg::check_type  start_check,
   input  cdd_pkg::check_type  end_check,
   output cdd_pkg::result_type result
);

   logic later;
   cdd_pkg::stamp_type lo;
   cdd_pkg::stamp_type hi;
   logic lo_leap;
   logic [cdd_pkg::MINUTE_W:0] mi;
   logic [cdd_pkg::HOUR_W:0] ho;
   logic [cdd_pkg::DAY_W:0] da;
   logic [cdd_pkg::MONTH_W:0] mo;
   logic [cdd_pkg::YEAR_W:0] ye;
   logic [cdd_pkg::MINUTE_W-1:0] mi_fix;
   logic [cdd_pkg::HOUR_W-1:0] ho_fix;
   logic [cdd_pkg::DAY_W-1:0] da_fix;
   logic [cdd_pkg::MONTH_W-1:0] mo_fix;

   always_comb begin
      later = {start_stamp.year, start_stamp.month, start_stamp.day, start_stamp.hour,
               start_stamp.minute}
            > {end_stamp.year, end_stamp.month, end_stamp.day, end_stamp.hour,
               end_stamp.minute};
      lo = later ? end_stamp : start_stamp;
      hi = later ? start_stamp : end_stamp;
      lo_leap = later ? end_check.leap : start_check.leap;

      // borrow chain from minutes up to years
      mi = {1'b0, hi.minute} - {1'b0, lo.minute};
      mi_fix = mi[cdd_pkg::MINUTE_W] ? mi[cdd_pkg::MINUTE_W-1:0] + cdd_pkg::MINUTES_PER_HOUR
                                     : mi[cdd_pkg::MINUTE_W-1:0];
      ho = {1'b0, hi.hour} - {1'b0, lo.hour}
         - {{cdd_pkg::HOUR_W{1'b0}}, mi[cdd_pkg::MINUTE_W]};
      ho_fix = ho[cdd_pkg::HOUR_W] ? ho[cdd_pkg::HOUR_W-1:0] + cdd_pkg::HOURS_PER_DAY
                                   : ho[cdd_pkg::HOUR_W-1:0];
      da = {1'b0, hi.day} - {1'b0, lo.day} - {{cdd_pkg::DAY_W{1'b0}}, ho[cdd_pkg::HOUR_W]};
      da_fix = da[cdd_pkg::DAY_W] ? da[cdd_pkg::DAY_W-1:0]
                                    + cdd_pkg::month_len(lo.month, lo_leap)
                                  : da[cdd_pkg::DAY_W-1:0];
      mo = {1'b0, hi.month} - {1'b0, lo.month}
         - {{cdd_pkg::MONTH_W{1'b0}}, da[cdd_pkg::DAY_W]};
      mo_fix = mo[cdd_pkg::MONTH_W] ? mo[cdd_pkg::MONTH_W-1:0] + cdd_pkg::MONTHS_PER_YEAR
                                    : mo[cdd_pkg::MONTH_W-1:0];
      ye = {1'b0, hi.year} - {1'b0, lo.year} - {{cdd_pkg::YEAR_W{1'b0}}, mo[cdd_pkg::MONTH_W]};

      result = '0;
      if (!start_check.ok) begin
         result.status = cdd_pkg::STATUS_START_BAD;
      end else if (!end_check.ok) begin
         result.status = cdd_pkg::STATUS_END_BAD;
      end else begin
         result.status = cdd_pkg::STATUS_OK;
         result.swapped = later;
         result.years = ye[cdd_pkg::YEAR_W] ? '0 : ye[cdd_pkg::YEAR_W-1:0];
         result.months = mo_fix;
         result.days = da_fix;
         result.hours = ho_fix;
         result.minutes = mi_fix;
      end
   end

endmodule
